[design/chbd_pkg.sv]
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; used by chbd_hex_parse and http_chunked_body_decoder_top.
package chbd_pkg;

  // Size line buffer depth; only LINE_BUF_BYTES-1 characters of a line are parsed.
  localparam int LINE_BUF_BYTES = 32;
  localparam int LEN_W          = $clog2(LINE_BUF_BYTES);

  // Chunk size magnitude width and saturation value.
  localparam int VAL_W = 31;
  localparam logic [VAL_W-1:0] SIZE_MAX = '1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [1:0] TRAILER_BYTES = 2'd2;

  typedef enum logic [2:0] {
    HP_WS,
    HP_SIGN,
    HP_ZERO,
    HP_PFX,
    HP_DIG,
    HP_DONE
  } hex_step_t;

  typedef struct packed {
    hex_step_t        step;
    logic [VAL_W-1:0] value;
    logic             neg;
  } parse_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

[design/chbd_hex_parse.sv]
// Next-state logic of the base-16 size line parser, one character per call.
// Depends on chbd_pkg.
module chbd_hex_parse (
  input  logic [7:0]            c,
  input  chbd_pkg::parse_state_t st,
  output chbd_pkg::parse_state_t st_nxt
);

  chbd_pkg::hex_digit_t         dig;
  logic                         is_ws;
  logic [chbd_pkg::VAL_W-1:0]   added;

  always_comb begin
    dig   = chbd_pkg::hex_digit(c);
    is_ws = (c == chbd_pkg::CH_SPACE) || (c == chbd_pkg::CH_TAB) ||
            (c == chbd_pkg::CH_CR) || (c == chbd_pkg::CH_VT) ||
            (c == chbd_pkg::CH_FF) || (c == chbd_pkg::CH_LF);
    // Shift in one digit; saturate when the top nibble would overflow.
    if (st.value[chbd_pkg::VAL_W-1 -: 4] != 4'd0) begin
      added = chbd_pkg::SIZE_MAX;
    end else begin
      added = {st.value[chbd_pkg::VAL_W-5:0], dig.val};
    end

    st_nxt = st;
    unique case (st.step)
      chbd_pkg::HP_WS: begin
        priority if (is_ws) begin
          st_nxt.step = chbd_pkg::HP_WS;
        end else if (c == chbd_pkg::CH_PLUS || c == chbd_pkg::CH_MINUS) begin
          st_nxt.neg  = (c == chbd_pkg::CH_MINUS);
          st_nxt.step = chbd_pkg::HP_SIGN;
        end else if (c == chbd_pkg::CH_ZERO) begin
          st_nxt.step = chbd_pkg::HP_ZERO;
        end else if (dig.ok) begin
          st_nxt.value = added;
          st_nxt.step  = chbd_pkg::HP_DIG;
        end else begin
          st_nxt.step = chbd_pkg::HP_DONE;
        end
      end
      chbd_pkg::HP_SIGN: begin
        priority if (c == chbd_pkg::CH_ZERO) begin
          st_nxt.step = chbd_pkg::HP_ZERO;
        end else if (dig.ok) begin
          st_nxt.value = added;
          st_nxt.step  = chbd_pkg::HP_DIG;
        end else begin
          st_nxt.step = chbd_pkg::HP_DONE;
        end
      end
      chbd_pkg::HP_ZERO: begin
        priority if (c == chbd_pkg::CH_X_LO || c == chbd_pkg::CH_X_UP) begin
          st_nxt.step = chbd_pkg::HP_PFX;
        end else if (dig.ok) begin
          st_nxt.value = added;
          st_nxt.step  = chbd_pkg::HP_DIG;
        end else begin
          st_nxt.step = chbd_pkg::HP_DONE;
        end
      end
      chbd_pkg::HP_PFX, chbd_pkg::HP_DIG: begin
        if (dig.ok) begin
          st_nxt.value = added;
          st_nxt.step  = chbd_pkg::HP_DIG;
        end else begin
          st_nxt.step = chbd_pkg::HP_DONE;
        end
      end
      default: begin
        st_nxt.step = chbd_pkg::HP_DONE;
      end
    endcase
  end

endmodule

[design/http_chunked_body_decoder_top.sv]
// HTTP/1.1 chunked transfer body decoder, top level.
// Depends on chbd_pkg and chbd_hex_parse.
//
// Usage:
//   in_  channel: one raw body word (in_stream_byte) per valid/ready handshake.
//   out_ channel: one decoded word per handshake: out_payload_byte, or
//                 out_end_of_body high (payload 0) for a zero-size chunk line.
//   cfg_ port:    cfg_wr_en writes cfg_wr_data into chunked_enable (reset 1).
//                 Write it only while the block is idle.
// With chunked_enable low every word passes through as payload. With it high,
// the block parses the hex size line up to LF, forwards that many payload
// words, drops the two trailer words and reads the next size line. Nonzero
// size lines, trailer words and ignored (negative) lines produce no output word.
// Timing: an accepted word is decoded while it sits in the input register and
// loads the output register when the decode stage advances. One word per
// cycle is sustained while out_ready stays high; each word only updates a
// handful of small registers. While a result waits, the input register
// still takes one more word.
// Reset (rst_n low, synchronous) returns to the size line phase, clears the
// parser and the valid flags of both pipeline registers and sets
// chunked_enable. When the receiver stalls, the output word holds and the input
// register fills, after which in_ready drops until out_ready returns.
module http_chunked_body_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_end_of_body,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  typedef enum logic [1:0] {
    PH_LINE,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Output register
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_eob_r;

  // Decoder state
  logic                                chunked_en_r;
  phase_t                              phase_r, phase_nxt;
  logic [chbd_pkg::VAL_W-1:0]          chunk_rem_r, chunk_rem_nxt;
  logic [1:0]                          trail_left_r, trail_left_nxt;
  logic [chbd_pkg::LEN_W-1:0]          line_len_r, line_len_nxt;
  chbd_pkg::parse_state_t              parse_r, parse_nxt, parse_upd;

  logic                                adv;
  logic                                res_vld;
  logic [7:0]                          res_byte;
  logic                                res_eob;
  logic [chbd_pkg::VAL_W-1:0]          rem_dec;
  logic [1:0]                          trail_dec;
  chbd_pkg::parse_state_t              parse_clr;

  // The decode stage moves whenever it holds a word and the output
  // register is free or being drained.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  assign out_valid        = out_vld_r;
  assign out_payload_byte = out_byte_r;
  assign out_end_of_body  = out_eob_r;

  chbd_hex_parse u_hex_parse (
    .c      (in_byte_r),
    .st     (parse_r),
    .st_nxt (parse_upd)
  );

  always_comb begin
    parse_clr.step  = chbd_pkg::HP_WS;
    parse_clr.value = '0;
    parse_clr.neg   = 1'b0;

    rem_dec   = (chunk_rem_r != '0) ? chunk_rem_r - 1'b1 : chunk_rem_r;
    trail_dec = (trail_left_r != 2'd0) ? trail_left_r - 2'd1 : trail_left_r;

    phase_nxt      = phase_r;
    chunk_rem_nxt  = chunk_rem_r;
    trail_left_nxt = trail_left_r;
    line_len_nxt   = line_len_r;
    parse_nxt      = parse_r;
    res_vld        = 1'b0;
    res_byte       = in_byte_r;
    res_eob        = 1'b0;

    if (!chunked_en_r) begin
      // Plain mode: pass the word, keep the framing state.
      res_vld = 1'b1;
    end else begin
      unique case (phase_r)
        PH_TRAIL: begin
          // Drop the trailer word.
          trail_left_nxt = trail_dec;
          if (trail_dec == 2'd0) begin
            phase_nxt = PH_LINE;
          end
        end
        PH_DATA: begin
          res_vld       = 1'b1;
          chunk_rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            trail_left_nxt = chbd_pkg::TRAILER_BYTES;
            phase_nxt      = PH_TRAIL;
          end
        end
        PH_LINE: begin
          if (in_byte_r == chbd_pkg::CH_LF) begin
            line_len_nxt = '0;
            parse_nxt    = parse_clr;
            if (parse_r.value == '0) begin
              // Zero size (also "-0" and a line without digits): end of body.
              chunk_rem_nxt = '0;
              res_vld       = 1'b1;
              res_byte      = 8'd0;
              res_eob       = 1'b1;
            end else if (!parse_r.neg) begin
              chunk_rem_nxt = parse_r.value;
              phase_nxt     = PH_DATA;
            end
          end else if (line_len_r < chbd_pkg::LEN_W'(chbd_pkg::LINE_BUF_BYTES - 1)) begin
            line_len_nxt = line_len_r + 1'b1;
            parse_nxt    = parse_upd;
          end
        end
        default: begin
          phase_nxt = PH_LINE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      chunked_en_r <= 1'b1;
      phase_r      <= PH_LINE;
      chunk_rem_r  <= '0;
      trail_left_r <= 2'd0;
      line_len_r   <= '0;
      parse_r      <= '{step: chbd_pkg::HP_WS, value: '0, neg: 1'b0};
    end else begin
      if (cfg_wr_en) begin
        chunked_en_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r    <= res_vld;
        phase_r      <= phase_nxt;
        chunk_rem_r  <= chunk_rem_nxt;
        trail_left_r <= trail_left_nxt;
        line_len_r   <= line_len_nxt;
        parse_r      <= parse_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_stream_byte;
    end
    if (adv) begin
      out_byte_r <= res_byte;
      out_eob_r  <= res_eob;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (chunk_rem_r != '0))
    else $error("payload phase with no bytes left");

  a_trail_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRAIL) |-> (trail_left_r != 2'd0))
    else $error("trailer phase with no bytes left");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= chbd_pkg::LEN_W'(chbd_pkg::LINE_BUF_BYTES - 1))
    else $error("line length beyond buffer");

  a_eob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_eob_r) |-> (out_byte_r == 8'd0))
    else $error("end of body with nonzero payload");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> in_vld_r)
    else $error("accepted word lost from input register");

endmodule
